FILE: design/lcp_pkg.sv
// shared types, constants and helpers for the lcd command packetizer
`default_nettype none

package lcp_pkg;

    localparam int CHUNK_BYTES   = 30;
    localparam int MAX_OUT_BYTES = 274 * 32;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 14;
    localparam int SUM_W   = 17;
    localparam int FILL_W  = $clog2(CHUNK_BYTES + 1);
    localparam int POS_W   = $clog2(CHUNK_BYTES + 2);

    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = $clog2(NUM_BANKS);
    localparam int MEM_DEPTH = NUM_BANKS * CHUNK_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 2);
    localparam int JOB_CNT_W  = $clog2(NUM_BANKS + 1);

    localparam logic [BYTE_W-1:0] SELECT_BYTE = 8'h02;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_PARAM   = 1'b1;

    localparam logic JOB_PACKET = 1'b0;
    localparam logic JOB_STATUS = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  cmd;
        logic [FILL_W-1:0]  fill;
        logic               last;
        logic [COUNT_W-1:0] taken;
        logic [COUNT_W-1:0] total;
    } job_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               run_last;
        logic               write_done;
        logic [COUNT_W-1:0] taken_count;
        logic [COUNT_W-1:0] total_length;
        logic               truncated;
    } result_t;

    function automatic logic [ADDR_W-1:0] chunk_addr(input logic [BANK_W-1:0] bank,
                                                     input logic [FILL_W-1:0] idx);
        return ADDR_W'(ADDR_W'(bank) * ADDR_W'(CHUNK_BYTES) + ADDR_W'(idx));
    endfunction

endpackage

`default_nettype wire

FILE: design/lcp_front.sv
// front end: takes input words, gathers chunks and queues packet jobs
`default_nettype none

module lcp_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic                  kind,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  last_byte,
    input  wire logic [lcp_pkg::BANK_W-1:0] wr_bank,
    output logic                       job_push,
    output lcp_pkg::job_t              job,
    output lcp_pkg::mem_wr_t           mem_wr
);
    import lcp_pkg::*;

    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] used_reg, used_next;
    logic [COUNT_W-1:0] consumed_reg, consumed_next;
    logic               ovf_reg, ovf_next;

    logic [FILL_W-1:0]  new_fill;
    logic [SUM_W-1:0]   sum_len;
    logic               chunk_end;
    logic               fits;

    assign new_fill  = FILL_W'(fill_reg + FILL_W'(1));
    assign sum_len   = SUM_W'(used_reg) + SUM_W'(new_fill) + SUM_W'(2);
    assign chunk_end = (new_fill == FILL_W'(CHUNK_BYTES)) || last_byte;
    assign fits      = (sum_len <= SUM_W'(MAX_OUT_BYTES));

    always_comb
    begin
        cmd_next      = cmd_reg;
        fill_next     = fill_reg;
        used_next     = used_reg;
        consumed_next = consumed_reg;
        ovf_next      = ovf_reg;
        job_push      = 1'b0;
        job.kind      = JOB_PACKET;
        job.cmd       = cmd_reg;
        job.fill      = new_fill;
        job.last      = last_byte;
        job.taken     = consumed_reg;
        job.total     = used_reg;
        mem_wr.we     = 1'b0;
        mem_wr.addr   = chunk_addr(wr_bank, fill_reg);
        mem_wr.data   = in_byte;
        if (accept)
        begin
            if (kind == KIND_COMMAND)
            begin
                cmd_next      = in_byte;
                fill_next     = '0;
                consumed_next = COUNT_W'(1);
                ovf_next      = 1'b0;
                used_next     = last_byte ? COUNT_W'(2) : '0;
                if (last_byte)
                begin
                    // lone command: select and command only
                    job_push  = 1'b1;
                    job.cmd   = in_byte;
                    job.fill  = '0;
                    job.last  = 1'b1;
                    job.taken = COUNT_W'(1);
                    job.total = COUNT_W'(2);
                end
            end
            else if (ovf_reg)
            begin
                if (last_byte)
                begin
                    job_push = 1'b1;
                    job.kind = JOB_STATUS;
                end
            end
            else
            begin
                mem_wr.we = 1'b1;
                fill_next = new_fill;
                if (chunk_end)
                begin
                    fill_next = '0;
                    if (!fits)
                    begin
                        ovf_next = 1'b1;
                        if (last_byte)
                        begin
                            job_push = 1'b1;
                            job.kind = JOB_STATUS;
                        end
                    end
                    else
                    begin
                        used_next     = COUNT_W'(sum_len);
                        consumed_next = COUNT_W'(consumed_reg + COUNT_W'(new_fill));
                        job_push      = 1'b1;
                        job.taken     = consumed_next;
                        job.total     = used_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= '0;
            fill_reg     <= '0;
            used_reg     <= '0;
            consumed_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            cmd_reg      <= cmd_next;
            fill_reg     <= fill_next;
            used_reg     <= used_next;
            consumed_reg <= consumed_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/lcp_job_queue.sv
// two-slot job queue; slot index doubles as the chunk buffer bank
`default_nettype none

module lcp_job_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lcp_pkg::job_t         push_job,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       empty,
    output lcp_pkg::job_t              head_job,
    output logic [lcp_pkg::BANK_W-1:0] wr_bank,
    output logic [lcp_pkg::BANK_W-1:0] rd_bank
);
    import lcp_pkg::*;

    job_t                 q_reg [NUM_BANKS];
    logic [BANK_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [JOB_CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == JOB_CNT_W'(NUM_BANKS));
    assign empty    = (cnt_reg == '0);
    assign head_job = q_reg[rd_ptr_reg];
    assign wr_bank  = wr_ptr_reg;
    assign rd_bank  = rd_ptr_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = JOB_CNT_W'(cnt_reg + JOB_CNT_W'(1));
        else if (pop && !push)
            cnt_next = JOB_CNT_W'(cnt_reg - JOB_CNT_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= BANK_W'(wr_ptr_reg + BANK_W'(1));
            if (pop)
                rd_ptr_reg <= BANK_W'(rd_ptr_reg + BANK_W'(1));
        end
    end

endmodule

`default_nettype wire

FILE: design/lcp_back.sv
// back end: chunk buffer, packet sequencer and result queue
`default_nettype none

module lcp_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    input  wire lcp_pkg::job_t         job,
    input  wire logic [lcp_pkg::BANK_W-1:0] rd_bank,
    input  wire lcp_pkg::mem_wr_t      mem_wr,
    input  wire logic                  pop,
    output logic                       job_pop,
    output logic                       empty,
    output lcp_pkg::result_t           head
);
    import lcp_pkg::*;

    logic [BYTE_W-1:0]    chunk_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]    rd_data_reg;

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     rd_tmp;
    logic [FILL_W-1:0]    rd_idx;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 issue;
    logic                 is_data;
    logic                 seq_last;
    logic                 cmd_end;
    logic                 data_end;
    result_t              res;

    logic                 pipe_valid_reg;
    logic                 pipe_mem_reg;
    result_t              pipe_res_reg;

    result_t              fifo_reg [OUT_DEPTH];
    result_t              fifo_in;
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 fifo_pop;
    logic                 room;

    // data bytes go out from the top of the chunk down
    assign rd_tmp   = POS_W'(POS_W'(job.fill) + POS_W'(1) - pos_reg);
    assign rd_idx   = rd_tmp[FILL_W-1:0];
    assign rd_addr  = chunk_addr(rd_bank, rd_idx);
    assign is_data  = (job.kind == JOB_PACKET) && (pos_reg > POS_W'(1));
    assign seq_last = (job.kind == JOB_STATUS) ||
                      (pos_reg == POS_W'(POS_W'(job.fill) + POS_W'(1)));
    assign cmd_end  = (job.fill == '0) && job.last;
    assign data_end = (rd_idx == '0);

    assign room    = (OUT_CNT_W'(cnt_reg + OUT_CNT_W'(pipe_valid_reg)) <
                      OUT_CNT_W'(OUT_DEPTH));
    assign issue   = job_valid && room;
    assign job_pop = issue && seq_last;

    always_comb
    begin
        res = '0;
        if (job.kind == JOB_STATUS)
        begin
            res.run_last     = 1'b1;
            res.write_done   = 1'b1;
            res.taken_count  = job.taken;
            res.total_length = job.total;
            res.truncated    = 1'b1;
        end
        else if (pos_reg == '0)
        begin
            res.out_byte   = SELECT_BYTE;
            res.byte_valid = 1'b1;
        end
        else if (pos_reg == POS_W'(1))
        begin
            res.out_byte   = job.cmd;
            res.byte_valid = 1'b1;
            res.run_last   = cmd_end;
            res.write_done = cmd_end;
            if (cmd_end)
            begin
                res.taken_count  = job.taken;
                res.total_length = job.total;
            end
        end
        else
        begin
            res.byte_valid = 1'b1;
            res.run_last   = data_end;
            res.write_done = data_end && job.last;
            if (data_end && job.last)
            begin
                res.taken_count  = job.taken;
                res.total_length = job.total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.we)
            chunk_mem[mem_wr.addr] <= mem_wr.data;
        if (issue && is_data)
            rd_data_reg <= chunk_mem[rd_addr];
    end

    always_comb
    begin
        fifo_in = pipe_res_reg;
        if (pipe_mem_reg)
            fifo_in.out_byte = rd_data_reg;
    end

    assign fifo_pop = pop && !empty;
    assign empty    = (cnt_reg == '0);
    assign head     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (pipe_valid_reg && !fifo_pop)
            cnt_next = OUT_CNT_W'(cnt_reg + OUT_CNT_W'(1));
        else if (fifo_pop && !pipe_valid_reg)
            cnt_next = OUT_CNT_W'(cnt_reg - OUT_CNT_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pipe_res_reg <= res;
            pipe_mem_reg <= is_data;
        end
        if (pipe_valid_reg)
            fifo_reg[wr_ptr_reg] <= fifo_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            pipe_valid_reg <= issue;
            if (issue)
                pos_reg <= seq_last ? '0 : POS_W'(pos_reg + POS_W'(1));
            cnt_reg <= cnt_next;
            if (pipe_valid_reg)
                wr_ptr_reg <= OUT_PTR_W'(wr_ptr_reg + OUT_PTR_W'(1));
            if (fifo_pop)
                rd_ptr_reg <= OUT_PTR_W'(rd_ptr_reg + OUT_PTR_W'(1));
        end
    end

endmodule

`default_nettype wire

FILE: design/lcd_command_packetizer.sv
// top level of the lcd command packetizer
//
//  channel   direction  handshake            words
//  input     in         push / full          kind, in_byte, last_byte
//  result    out        pop / empty          out_byte, byte_valid, run_last,
//                                            write_done, taken_count,
//                                            total_length, truncated
//
// an input word is taken whenever push is high and full is low; a chunk of n
// parameter bytes leaves as n + 2 result words, one per cycle while the result
// queue has room, and the packet sequencer sets the sustained rate
// a chunk's first result word passes the job queue and the pipeline register before the result queue
// two chunk buffer banks: full rises while both hold jobs not yet sent
// reset clears all counters, pointers and the write state; the chunk buffer
// is not cleared, only bytes written in the current chunk are ever read
`default_nettype none

module lcd_command_packetizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        kind,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             run_last,
    output logic             write_done,
    output logic [13:0]      taken_count,
    output logic [13:0]      total_length,
    output logic             truncated
);
    import lcp_pkg::*;

    logic              accept;
    logic              job_push;
    logic              job_pop;
    logic              q_full;
    logic              q_empty;
    job_t              new_job;
    job_t              head_job;
    mem_wr_t           mem_wr;
    logic [BANK_W-1:0] wr_bank;
    logic [BANK_W-1:0] rd_bank;
    result_t           head;

    // a word is only taken while the bank it would fill is free
    assign full   = q_full;
    assign accept = push && !q_full;

    lcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .wr_bank   (wr_bank),
        .job_push  (job_push),
        .job       (new_job),
        .mem_wr    (mem_wr)
    );

    lcp_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_job (head_job),
        .wr_bank  (wr_bank),
        .rd_bank  (rd_bank)
    );

    lcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (head_job),
        .rd_bank   (rd_bank),
        .mem_wr    (mem_wr),
        .pop       (pop),
        .job_pop   (job_pop),
        .empty     (empty),
        .head      (head)
    );

    // oldest waiting result word on the ports
    assign out_byte     = head.out_byte;
    assign byte_valid   = head.byte_valid;
    assign run_last     = head.run_last;
    assign write_done   = head.write_done;
    assign taken_count  = head.taken_count;
    assign total_length = head.total_length;
    assign truncated    = head.truncated;

endmodule

`default_nettype wire
